// ===== sv/wvm_pkg.sv =====
// shared types and constants of the wavetable voice mixer
`timescale 1ns / 1ps

package wvm_pkg;

  localparam int NUM_VOICES_DEF    = 32;
  localparam int SAMPLE_WORDS_DEF  = 65536;
  localparam int FRACTION_BITS_DEF = 8;

  localparam logic [9:0] MASTER_VOLUME_RESET = 10'd179;
  localparam logic signed [31:0] SAT_MAX = 32'sd32767;
  localparam logic signed [31:0] SAT_MIN = -32'sd32767;
  localparam logic signed [16:0] NARROW_BIAS = 17'sd128;

  localparam logic [2:0] OP_WRITE  = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1;
  localparam logic [2:0] OP_STOP   = 3'd2;
  localparam logic [2:0] OP_VOLUME = 3'd3;
  localparam logic [2:0] OP_MIX    = 3'd4;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [4:0]  voice;
    logic [15:0] address;
    logic [15:0] value;
    logic [16:0] length;
    logic [15:0] loop_start;
    logic        looped;
    logic [11:0] step;
    logic        is_8bit;
    logic [9:0]  left_volume;
    logic [9:0]  right_volume;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_VOL_WRITE,
    S_MIX_CHECK,
    S_MIX_EVAL,
    S_WRAP_WAIT,
    S_ADDR,
    S_SREAD,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_ACC,
    S_NEXT,
    S_DONE
  } wvm_state_t;

endpackage

// ===== sv/wvm_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module wvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/wvm_modulo.sv =====
// bit-serial restoring remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps

module wvm_modulo #(
  parameter int MOD_W = 26
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [MOD_W-1:0] dividend,
  input  logic [MOD_W-1:0] divisor,
  output logic             done,
  output logic [MOD_W-1:0] remainder
);

  localparam int CW = $clog2(MOD_W + 1);

  logic [MOD_W:0]   rem;
  logic [MOD_W-1:0] quo;
  logic [MOD_W-1:0] div;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [MOD_W:0]   trial;
  logic [MOD_W:0]   rem_next;

  always_comb begin
    trial = {rem[MOD_W-1:0], quo[MOD_W-1]};
    if (trial >= {1'b0, div}) begin
      rem_next = trial - {1'b0, div};
    end else begin
      rem_next = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(MOD_W);
        rem  <= '0;
        quo  <= dividend;
        div  <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        quo <= quo << 1;
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign remainder = rem[MOD_W-1:0];

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("remainder done without a running division");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !start)
    else $error("division restarted while busy");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> (rem < {1'b0, div}))
    else $error("remainder not below divisor");

endmodule

// ===== sv/wavetable_voice_mixer.sv =====
// Stereo wavetable mixer over a table of voices. Items are taken one at a time. A mix frame walks
// every voice; when a looped voice wraps, it waits for the bit-serial remainder unit of MOD_W bits
// (MOD_W = 18 + FRACTION_BITS, 26 by default). A frame also waits while the previous result is
// still stalled at the output. Voice records and samples sit in registered-read RAMs; of the
// voice state only the active flags are reset, so no clearing pass runs after reset.
// SAMPLE_WORDS must be a power of two: sample addresses wrap at that size.
`timescale 1ns / 1ps

module wavetable_voice_mixer #(
  parameter int NUM_VOICES    = wvm_pkg::NUM_VOICES_DEF,
  parameter int SAMPLE_WORDS  = wvm_pkg::SAMPLE_WORDS_DEF,
  parameter int FRACTION_BITS = wvm_pkg::FRACTION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  wvm_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output wvm_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [9:0]        cfg_data
);

  localparam int AW    = $clog2(SAMPLE_WORDS);
  localparam int VI_W  = $clog2(NUM_VOICES);
  localparam int POS_W = 18 + FRACTION_BITS;
  localparam int MOD_W = POS_W;

  typedef struct packed {
    logic [15:0]      base;
    logic [16:0]      length;
    logic [16:0]      loop;     // bit 16 set means not looped
    logic [11:0]      step;
    logic             narrow;
    logic [9:0]       right_gain;
    logic [9:0]       left_gain;
    logic [POS_W-1:0] position;
  } voice_rec_t;

  localparam int REC_W = $bits(voice_rec_t);

  wvm_pkg::wvm_state_t state, state_next;
  wvm_pkg::in_item_t   item;

  logic [9:0]            master_volume;
  logic [NUM_VOICES-1:0] active;
  logic [VI_W-1:0]       vidx;
  logic [VI_W-1:0]       vsel;
  logic                  voice_ok;
  logic                  last_voice;
  voice_rec_t            vrec;
  voice_rec_t            vram_rdata;
  voice_rec_t            vram_wdata;
  logic                  vram_we;
  logic [VI_W-1:0]       vram_waddr;
  logic [VI_W-1:0]       vram_raddr;
  logic [REC_W-1:0]      vram_rbits;
  logic [POS_W-1:0]      posr;
  logic [AW-1:0]         saddr;
  logic                  sram_we;
  logic [15:0]           sram_rdata;
  logic                  mod_start;
  logic [MOD_W-1:0]      mod_dividend;
  logic [MOD_W-1:0]      mod_divisor;
  logic                  mod_done;
  logic [MOD_W-1:0]      mod_rem;
  logic [MOD_W-1:0]      len_fx;
  logic                  at_end;
  logic                  gains_zero;
  logic                  stops;
  logic                  out_load;
  logic signed [16:0]    sval;
  logic signed [27:0]    prod_l, prod_r;
  logic signed [27:0]    shl, shr;
  logic signed [27:0]    quo_l, quo_r;
  logic signed [38:0]    mprod_l, mprod_r;
  logic signed [31:0]    sum_l, sum_r;
  logic signed [31:0]    sat_l, sat_r;

  assign cfg_ready  = 1'b1;
  assign in_stall   = (state != wvm_pkg::S_IDLE);
  assign vsel       = VI_W'(item.voice);
  assign voice_ok   = ({27'd0, item.voice} < NUM_VOICES);
  assign last_voice = (vidx == VI_W'(NUM_VOICES - 1));
  assign vram_rdata = voice_rec_t'(vram_rbits);

  // checks on the freshly read record
  assign len_fx     = MOD_W'({vram_rdata.length, {FRACTION_BITS{1'b0}}});
  assign at_end     = (MOD_W'(vram_rdata.position) >= len_fx);
  assign gains_zero = (vram_rdata.left_gain == '0) && (vram_rdata.right_gain == '0);
  assign stops      = vram_rdata.loop[16] || (vram_rdata.length == '0);

  always_comb begin
    state_next = state;
    unique case (state)
      wvm_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = wvm_pkg::S_DECODE;
        end
      end
      wvm_pkg::S_DECODE: begin
        unique case (item.opcode)
          wvm_pkg::OP_VOLUME: state_next = voice_ok ? wvm_pkg::S_VOL_WRITE : wvm_pkg::S_IDLE;
          wvm_pkg::OP_MIX:    state_next = wvm_pkg::S_MIX_CHECK;
          default:            state_next = wvm_pkg::S_IDLE;
        endcase
      end
      wvm_pkg::S_VOL_WRITE: state_next = wvm_pkg::S_IDLE;
      wvm_pkg::S_MIX_CHECK: begin
        state_next = active[vidx] ? wvm_pkg::S_MIX_EVAL : wvm_pkg::S_NEXT;
      end
      wvm_pkg::S_MIX_EVAL: begin
        if (gains_zero) begin
          state_next = wvm_pkg::S_NEXT;
        end else if (at_end) begin
          state_next = stops ? wvm_pkg::S_NEXT : wvm_pkg::S_WRAP_WAIT;
        end else begin
          state_next = wvm_pkg::S_ADDR;
        end
      end
      wvm_pkg::S_WRAP_WAIT: begin
        if (mod_done) begin
          state_next = wvm_pkg::S_ADDR;
        end
      end
      wvm_pkg::S_ADDR:  state_next = wvm_pkg::S_SREAD;
      wvm_pkg::S_SREAD: state_next = wvm_pkg::S_MUL1;
      wvm_pkg::S_MUL1:  state_next = wvm_pkg::S_MUL2;
      wvm_pkg::S_MUL2:  state_next = wvm_pkg::S_MUL3;
      wvm_pkg::S_MUL3:  state_next = wvm_pkg::S_ACC;
      wvm_pkg::S_ACC:   state_next = wvm_pkg::S_NEXT;
      wvm_pkg::S_NEXT: begin
        state_next = last_voice ? wvm_pkg::S_DONE : wvm_pkg::S_MIX_CHECK;
      end
      wvm_pkg::S_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = wvm_pkg::S_IDLE;
        end
      end
      default: state_next = wvm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mod_start    = 1'b0;
    mod_dividend = MOD_W'(vram_rdata.position);
    mod_divisor  = len_fx;
    vram_we      = 1'b0;
    vram_waddr   = vsel;
    vram_wdata   = vram_rdata;
    sram_we      = 1'b0;
    out_load     = 1'b0;
    vram_raddr   = vsel;
    unique case (state)
      wvm_pkg::S_DECODE: begin
        if (item.opcode == wvm_pkg::OP_WRITE) begin
          sram_we = 1'b1;
        end
        if (item.opcode == wvm_pkg::OP_LOAD && voice_ok) begin
          vram_we               = 1'b1;
          vram_wdata.base       = item.address;
          vram_wdata.length     = item.length;
          vram_wdata.loop       = {!item.looped, item.loop_start};
          vram_wdata.step       = item.step;
          vram_wdata.narrow     = item.is_8bit;
          vram_wdata.left_gain  = item.left_volume;
          vram_wdata.right_gain = item.right_volume;
          vram_wdata.position   = POS_W'({item.value, {FRACTION_BITS{1'b0}}});
        end
      end
      wvm_pkg::S_VOL_WRITE: begin
        vram_we               = 1'b1;
        vram_wdata.left_gain  = item.left_volume;
        vram_wdata.right_gain = item.right_volume;
      end
      wvm_pkg::S_MIX_CHECK: vram_raddr = vidx;
      wvm_pkg::S_MIX_EVAL: begin
        vram_raddr = vidx;
        mod_start  = !gains_zero && at_end && !stops;
      end
      wvm_pkg::S_ACC: begin
        vram_raddr          = vidx;
        vram_we             = 1'b1;
        vram_waddr          = vidx;
        vram_wdata          = vrec;
        vram_wdata.position = posr + POS_W'(vrec.step);
      end
      wvm_pkg::S_DONE: out_load = !out_valid || !out_stall;
      default:         vram_raddr = vidx;
    endcase
  end

  // sample scaling datapath
  always_comb begin
    if (vrec.narrow) begin
      sval = $signed({9'd0, sram_rdata[7:0]}) - wvm_pkg::NARROW_BIAS;
    end else begin
      sval = $signed({sram_rdata[15], sram_rdata});
    end
    shl = vrec.narrow ? prod_l : (prod_l >>> 8);
    shr = vrec.narrow ? prod_r : (prod_r >>> 8);
    sat_l = (sum_l > wvm_pkg::SAT_MAX) ? wvm_pkg::SAT_MAX :
            (sum_l < wvm_pkg::SAT_MIN) ? wvm_pkg::SAT_MIN : sum_l;
    sat_r = (sum_r > wvm_pkg::SAT_MAX) ? wvm_pkg::SAT_MAX :
            (sum_r < wvm_pkg::SAT_MIN) ? wvm_pkg::SAT_MIN : sum_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= wvm_pkg::S_IDLE;
      active        <= '0;
      master_volume <= wvm_pkg::MASTER_VOLUME_RESET;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        master_volume <= cfg_data;
      end
      if (state == wvm_pkg::S_DECODE && voice_ok) begin
        if (item.opcode == wvm_pkg::OP_LOAD) begin
          active[vsel] <= 1'b1;
        end else if (item.opcode == wvm_pkg::OP_STOP) begin
          active[vsel] <= 1'b0;
        end
      end
      if (state == wvm_pkg::S_MIX_EVAL && !gains_zero && at_end && stops) begin
        active[vidx] <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == wvm_pkg::S_IDLE && in_valid) begin
      item <= in_data;
    end
    if (state == wvm_pkg::S_DECODE) begin
      vidx  <= '0;
      sum_l <= '0;
      sum_r <= '0;
    end
    if (state == wvm_pkg::S_NEXT && !last_voice) begin
      vidx <= vidx + VI_W'(1);
    end
    if (state == wvm_pkg::S_MIX_EVAL) begin
      vrec <= vram_rdata;
      posr <= vram_rdata.position;
    end
    if (state == wvm_pkg::S_WRAP_WAIT && mod_done) begin
      posr <= POS_W'({vrec.loop[15:0], {FRACTION_BITS{1'b0}}}) + POS_W'(mod_rem);
    end
    // sample address wraps at the power-of-two memory size
    if (state == wvm_pkg::S_ADDR) begin
      saddr <= AW'(MOD_W'(vrec.base) + MOD_W'(posr >> FRACTION_BITS));
    end
    if (state == wvm_pkg::S_MUL1) begin
      prod_l <= 28'(sval * $signed({1'b0, vrec.left_gain}));
      prod_r <= 28'(sval * $signed({1'b0, vrec.right_gain}));
    end
    if (state == wvm_pkg::S_MUL2) begin
      // divide by eight toward zero
      quo_l <= (shl < 0) ? ((shl + 28'sd7) >>> 3) : (shl >>> 3);
      quo_r <= (shr < 0) ? ((shr + 28'sd7) >>> 3) : (shr >>> 3);
    end
    if (state == wvm_pkg::S_MUL3) begin
      mprod_l <= 39'(quo_l * $signed({1'b0, master_volume}));
      mprod_r <= 39'(quo_r * $signed({1'b0, master_volume}));
    end
    if (state == wvm_pkg::S_ACC) begin
      sum_l <= sum_l + 32'(mprod_l >>> 8);
      sum_r <= sum_r + 32'(mprod_r >>> 8);
    end
    if (out_load) begin
      out_data.left_sample  <= sat_l[15:0];
      out_data.right_sample <= sat_r[15:0];
    end
  end

  wvm_modulo #(
    .MOD_W(MOD_W)
  ) u_modulo (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .done     (mod_done),
    .remainder(mod_rem)
  );

  wvm_ram #(
    .WIDTH(REC_W),
    .DEPTH(NUM_VOICES)
  ) u_voice_ram (
    .clk  (clk),
    .we   (vram_we),
    .waddr(vram_waddr),
    .wdata(REC_W'(vram_wdata)),
    .raddr(vram_raddr),
    .rdata(vram_rbits)
  );

  wvm_ram #(
    .WIDTH(16),
    .DEPTH(SAMPLE_WORDS)
  ) u_sample_ram (
    .clk  (clk),
    .we   (sram_we),
    .waddr(AW'(item.address)),
    .wdata(item.value),
    .raddr(saddr),
    .rdata(sram_rdata)
  );

  a_out_from_mix: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == wvm_pkg::S_DONE))
    else $error("result beat without a finished mix");

  a_mod_done_waited: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == wvm_pkg::S_WRAP_WAIT))
    else $error("remainder finished while nobody waits");

  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.left_sample != 16'sh8000 && out_data.right_sample != 16'sh8000))
    else $error("output outside saturation range");

  a_mix_only_active: assert property (@(posedge clk) disable iff (rst)
    (state == wvm_pkg::S_MIX_EVAL) |-> $past(active[vidx]))
    else $error("inactive voice evaluated");

endmodule

// ===== sim/wvm_checker.sv =====
// checker for the wavetable voice mixer: watches the channels, predicts frames and compares
`timescale 1ns / 1ps

module wvm_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  wvm_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  wvm_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [9:0]         cfg_data,
  output int                 errors,
  output int                 pending
);

  logic [15:0] sample_mem [0:65535];
  logic        vact    [32];
  logic [15:0] vbase   [32];
  logic [16:0] vlen    [32];
  logic [16:0] vloop   [32];
  logic [11:0] vstep   [32];
  logic        vnarrow [32];
  logic [9:0]  lgain   [32];
  logic [9:0]  rgain   [32];
  logic [31:0] vpos    [32];
  logic [9:0]  master;
  wvm_pkg::out_item_t frame_q [$];

  function automatic longint floor256(longint x);
    return (x >= 0) ? x / 256 : -((-x + 255) / 256);
  endfunction

  function automatic longint scale_gain(longint s, logic [9:0] g, logic narrow);
    longint gl;
    longint v;
    gl = longint'(g);
    v = s * gl;
    if (!narrow) v = floor256(v);
    v = v / 8;
    return floor256(v * longint'(master));
  endfunction

  function automatic logic signed [15:0] clip(longint x);
    if (x > 32767) return 16'sd32767;
    if (x < -32767) return -16'sd32767;
    return x[15:0];
  endfunction

  // walks all voices, advances positions and returns the frame
  function automatic wvm_pkg::out_item_t mix_frame();
    longint lsum;
    longint rsum;
    longint s;
    logic [31:0] len_fx;
    logic [31:0] pos;
    logic [15:0] word;
    logic [15:0] addr;
    wvm_pkg::out_item_t f;
    lsum = 0;
    rsum = 0;
    for (int i = 0; i < 32; i++) begin
      if (!vact[i] || (lgain[i] == 0 && rgain[i] == 0)) continue;
      len_fx = {7'd0, vlen[i], 8'd0};
      pos = vpos[i];
      if (pos >= len_fx) begin
        if (vloop[i][16] || len_fx == 0) begin
          vact[i] = 1'b0;
          continue;
        end
        pos = {8'd0, vloop[i][15:0], 8'd0} + pos % len_fx;
      end
      addr = vbase[i] + 16'(pos >> 8);
      word = sample_mem[addr];
      if (vnarrow[i]) s = longint'(word[7:0]) - 128;
      else s = longint'($signed(word));
      lsum += scale_gain(s, lgain[i], vnarrow[i]);
      rsum += scale_gain(s, rgain[i], vnarrow[i]);
      vpos[i] = pos + 32'(vstep[i]);
    end
    f.left_sample = clip(lsum);
    f.right_sample = clip(rsum);
    return f;
  endfunction

  always @(posedge clk) begin
    wvm_pkg::out_item_t exp_f;
    if (rst) begin
      for (int i = 0; i < 32; i++) vact[i] = 1'b0;
      master = wvm_pkg::MASTER_VOLUME_RESET;
      frame_q.delete();
      errors <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (frame_q.size() == 0) begin
          $display("%0t: frame with none expected, actual %0d %0d", $time,
                   out_data.left_sample, out_data.right_sample);
          errors <= errors + 1;
        end else begin
          exp_f = frame_q.pop_front();
          if (exp_f != out_data) begin
            if (exp_f.left_sample != out_data.left_sample)
              $display("%0t: left mismatch, expected %0d actual %0d", $time,
                       exp_f.left_sample, out_data.left_sample);
            if (exp_f.right_sample != out_data.right_sample)
              $display("%0t: right mismatch, expected %0d actual %0d", $time,
                       exp_f.right_sample, out_data.right_sample);
            errors <= errors + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) master = cfg_data;
      if (in_valid && !in_stall) begin
        case (in_data.opcode)
          wvm_pkg::OP_WRITE: sample_mem[in_data.address] = in_data.value;
          wvm_pkg::OP_LOAD: begin
            vbase[in_data.voice]   = in_data.address;
            vlen[in_data.voice]    = in_data.length;
            vloop[in_data.voice]   = {!in_data.looped, in_data.loop_start};
            vstep[in_data.voice]   = in_data.step;
            vnarrow[in_data.voice] = in_data.is_8bit;
            vpos[in_data.voice]    = {8'd0, in_data.value, 8'd0};
            vact[in_data.voice]    = 1'b1;
            lgain[in_data.voice]   = in_data.left_volume;
            rgain[in_data.voice]   = in_data.right_volume;
          end
          wvm_pkg::OP_STOP: vact[in_data.voice] = 1'b0;
          wvm_pkg::OP_VOLUME: begin
            lgain[in_data.voice] = in_data.left_volume;
            rgain[in_data.voice] = in_data.right_volume;
          end
          wvm_pkg::OP_MIX: frame_q.push_back(mix_frame());
          default: ;
        endcase
      end
    end
    pending <= frame_q.size();
  end

endmodule

// ===== sim/tb.sv =====
// testbench top for the wavetable voice mixer: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb;

  localparam logic [15:0] WIN_BASE = 16'hFF80;  // 256 written words, wrapping past zero
  localparam int LIMIT = 20000000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  wvm_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  wvm_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [9:0]         cfg_data = '0;
  int                 errors;
  int                 pending;
  int                 cycles = 0;
  logic               calm = 1'b0;
  logic               unsafe_v [32];

  always #2 clk = ~clk;

  wavetable_voice_mixer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  wvm_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int pause();
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  // receiver side: stall for a drawn number of cycles, then take one beat
  initial begin
    int n;
    @(negedge rst);
    forever begin
      n = pause();
      repeat (n) @(negedge clk) out_stall <= 1'b1;
      @(negedge clk) out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send(wvm_pkg::in_item_t it);
    int n;
    n = pause();
    repeat (n) @(negedge clk) in_valid <= 1'b0;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_master(logic [9:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  function automatic wvm_pkg::in_item_t noise();
    wvm_pkg::in_item_t it;
    it.opcode       = 3'($urandom);
    it.voice        = 5'($urandom);
    it.address      = 16'($urandom);
    it.value        = 16'($urandom);
    it.length       = 17'($urandom);
    it.loop_start   = 16'($urandom);
    it.looped       = 1'($urandom);
    it.step         = 12'($urandom);
    it.is_8bit      = 1'($urandom);
    it.left_volume  = 10'($urandom);
    it.right_volume = 10'($urandom);
    return it;
  endfunction

  // voice whose reads all fall inside the written window
  function automatic wvm_pkg::in_item_t load_voice(logic [4:0] v);
    wvm_pkg::in_item_t it;
    int b;
    int avail;
    int len;
    it = noise();
    b = $urandom_range(0, 250);
    avail = 256 - b;
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, avail) : $urandom_range(1, 12);
    if (len > avail) len = avail;
    it.opcode  = wvm_pkg::OP_LOAD;
    it.voice   = v;
    it.address = WIN_BASE + 16'(b);
    it.length  = 17'(len);
    if (it.looped) it.loop_start = 16'($urandom_range(0, avail - len));
    if ($urandom_range(0, 2) != 0) it.value = 16'($urandom_range(0, len));
    it.step = 12'($urandom_range(1, 4095));
    if ($urandom_range(0, 7) == 0) begin
      it.left_volume = '0;
      it.right_volume = '0;
    end
    unsafe_v[v] = 1'b0;
    return it;
  endfunction

  // voice that may point anywhere, kept silent so it never reads
  function automatic wvm_pkg::in_item_t load_silent(logic [4:0] v);
    wvm_pkg::in_item_t it;
    it = noise();
    it.opcode = wvm_pkg::OP_LOAD;
    it.voice = v;
    it.length = ($urandom_range(0, 3) == 0) ? 17'h10000 : 17'($urandom_range(1, 65536));
    it.left_volume = '0;
    it.right_volume = '0;
    unsafe_v[v] = 1'b1;
    return it;
  endfunction

  function automatic wvm_pkg::in_item_t set_gains(logic [4:0] v, logic [9:0] l, logic [9:0] r);
    wvm_pkg::in_item_t it;
    it = noise();
    it.opcode = wvm_pkg::OP_VOLUME;
    it.voice = v;
    it.left_volume = unsafe_v[v] ? 10'd0 : l;
    it.right_volume = unsafe_v[v] ? 10'd0 : r;
    return it;
  endfunction

  function automatic wvm_pkg::in_item_t with_op(logic [2:0] op, logic [4:0] v);
    wvm_pkg::in_item_t it;
    it = noise();
    it.opcode = op;
    it.voice = v;
    return it;
  endfunction

  function automatic wvm_pkg::in_item_t random_item();
    wvm_pkg::in_item_t it;
    int k;
    logic [4:0] v;
    k = $urandom_range(0, 99);
    v = 5'($urandom);
    if (k < 18) begin
      it = with_op(wvm_pkg::OP_WRITE, v);
      it.address = WIN_BASE + 16'($urandom_range(0, 255));
    end else if (k < 22) begin
      it = with_op(wvm_pkg::OP_WRITE, v);
      it.address = 16'($urandom_range(16'h0080, 16'hFF7F));
    end else if (k < 42) it = load_voice(v);
    else if (k < 46) it = load_silent(v);
    else if (k < 54) it = with_op(wvm_pkg::OP_STOP, v);
    else if (k < 64) it = set_gains(v, 10'($urandom), 10'($urandom));
    else if (k < 97) it = with_op(wvm_pkg::OP_MIX, v);
    else it = with_op(3'($urandom_range(5, 7)), v);
    return it;
  endfunction

  initial begin
    wvm_pkg::in_item_t it;
    logic [15:0] w;
    logic [9:0] settings [5];
    for (int i = 0; i < 32; i++) unsafe_v[i] = 1'b0;
    settings = '{10'd0, 10'd512, 10'd256, 10'($urandom_range(1, 511)), 10'd179};
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    calm = 1'b0;

    // fill the sample window, extremes at the front
    for (int i = 0; i < 256; i++) begin
      case (i)
        0: w = 16'h7FFF;
        1: w = 16'h8000;
        2: w = 16'h0000;
        3: w = 16'hFFFF;
        8: w = 16'h00FF;
        9: w = 16'hFF00;
        default: w = 16'($urandom);
      endcase
      it = with_op(wvm_pkg::OP_WRITE, 5'd0);
      it.address = WIN_BASE + 16'(i);
      it.value = w;
      send(it);
    end

    // directed frames
    it = load_voice(5'd0);
    it.address = WIN_BASE; it.length = 17'd4; it.looped = 1'b1; it.loop_start = 16'd0;
    it.value = 16'd0; it.step = 12'd256; it.is_8bit = 1'b0;
    it.left_volume = 10'd1023; it.right_volume = 10'd1023;
    send(it);
    it = load_voice(5'd31);
    it.address = WIN_BASE + 16'd8; it.length = 17'd8; it.looped = 1'b0; it.value = 16'd0;
    it.step = 12'd4095; it.is_8bit = 1'b1; it.left_volume = 10'd1023; it.right_volume = 10'd0;
    send(it);
    send(with_op(wvm_pkg::OP_MIX, 5'd0));
    // zero length voice drops out at the next frame
    it = load_voice(5'd5);
    it.length = 17'd0; it.left_volume = 10'd5; it.right_volume = 10'd5;
    send(it);
    // voice whose loop start lies past its length
    it = load_voice(5'd6);
    it.address = WIN_BASE + 16'd20; it.length = 17'd3; it.looped = 1'b1;
    it.loop_start = 16'd40; it.step = 12'd100; it.value = 16'd0;
    it.left_volume = 10'd300; it.right_volume = 10'd700;
    send(it);
    // start offset past the length
    it = load_voice(5'd7);
    it.address = WIN_BASE; it.length = 17'd10; it.looped = 1'b0; it.value = 16'hFFFF;
    it.left_volume = 10'd1; it.right_volume = 10'd1;
    send(it);
    it = load_silent(5'd8);
    it.length = 17'h10000; it.address = 16'hFFFF; it.value = 16'hFFFF; it.loop_start = 16'hFFFF;
    send(it);
    send(set_gains(5'd9, 10'd1023, 10'd1023));
    send(with_op(wvm_pkg::OP_MIX, 5'd0));
    send(with_op(wvm_pkg::OP_MIX, 5'd0));
    send(with_op(wvm_pkg::OP_STOP, 5'd0));
    send(with_op(3'd7, 5'd3));
    it = with_op(wvm_pkg::OP_WRITE, 5'd0);
    it.address = 16'h4000; it.value = 16'hFFFF;
    send(it);
    send(with_op(wvm_pkg::OP_MIX, 5'd0));
    send(set_gains(5'd31, 10'd0, 10'd0));
    send(with_op(wvm_pkg::OP_MIX, 5'd0));
    send(set_gains(5'd31, 10'd512, 10'd512));
    send(with_op(wvm_pkg::OP_MIX, 5'd0));

    // random phases under several master volumes
    for (int p = 0; p < 5; p++) begin
      write_master(settings[p]);
      for (int n = 0; n < 215; n++) begin
        if (n % 90 == 0) calm = ($urandom_range(0, 3) == 0);
        send(random_item());
      end
    end

    @(negedge clk) in_valid <= 1'b0;
    calm = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== wavetable_voice_mixer.f =====
sv/wvm_pkg.sv
sv/wvm_ram.sv
sv/wvm_modulo.sv
sv/wavetable_voice_mixer.sv
sim/wvm_checker.sv
sim/tb.sv
